[hw/rtl/pt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pt_pkg
// Shared types and constants for the peer table with aging.
// ----------------------------------------------------------------------------
package pt_pkg;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 16;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_TTL     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BEACON_INTVL = 1'b1;

    localparam logic [31:0] TTL_RESET      = 32'd5000;
    localparam logic [31:0] INTERVAL_RESET = 32'd1000;

    // item opcodes
    localparam logic OP_RX    = 1'b0;
    localparam logic OP_AGING = 1'b1;

    // packet header
    localparam logic [7:0] HDR_BYTES        = 8'd4;
    localparam logic [7:0] TYPE_PLAYER_INFO = 8'd1;

    // result status codes
    typedef enum logic [2:0] {
        ST_SHORT     = 3'd0,
        ST_ADDED     = 3'd1,
        ST_REFRESHED = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_FULL      = 3'd4,
        ST_AGED      = 3'd5
    } status_t;

    // one table slot as held in the slot memory
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] last_seen;
        logic [7:0]  side;
        logic        hunter;
    } peer_entry_t;

    // latched input item
    typedef struct packed {
        logic        opcode;
        logic [31:0] now_ms;
        logic [47:0] src_mac;
        logic [7:0]  pkt_len;
        logic [7:0]  pkt_type;
        logic [7:0]  side;
        logic        is_hunter;
    } item_t;

endpackage
`default_nettype wire

[hw/rtl/pt_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pt_if
// Valid/ready channels: input items and result items.
// ----------------------------------------------------------------------------
interface pt_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] now_ms;
    logic [47:0] src_mac;
    logic [7:0]  pkt_len;
    logic [7:0]  pkt_type;
    logic [7:0]  side;
    logic        is_hunter;

    modport source (
        output valid, opcode, now_ms, src_mac, pkt_len, pkt_type, side, is_hunter,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_ms, src_mac, pkt_len, pkt_type, side, is_hunter,
        output ready
    );
endinterface

interface pt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] slot_index;
    logic [4:0] removed_count;
    logic [4:0] occupancy;
    logic       broadcast_due;

    modport source (
        output valid, status, slot_index, removed_count, occupancy, broadcast_due,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, removed_count, occupancy, broadcast_due,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/pt_slot_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pt_slot_mem
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pt_slot_mem
    import pt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [IW-1:0] rd_addr,
    output peer_entry_t        rd_data,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire peer_entry_t   wr_data
);

    peer_entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/pt_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pt_engine
// Slot scan sequencer: match, refresh, insert and expiry over the slot
// memory, valid bits and occupancy count, plus the beacon timer and the result register.
// ----------------------------------------------------------------------------
module pt_engine
    import pt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [31:0]   peer_ttl_ms,
    input  wire logic [31:0]   beacon_interval_ms,
    pt_in_if.sink              item,
    pt_out_if.source           result,
    output logic               rd_en,
    output logic [IW-1:0]      rd_addr,
    input  wire peer_entry_t   rd_data,
    output logic               wr_en,
    output logic [IW-1:0]      wr_addr,
    output peer_entry_t        wr_data
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

    state_t          state_reg, state_next;
    item_t           item_reg, item_next;
    logic [CW-1:0]   addr_reg, addr_next;
    logic            chk_vld_reg, chk_vld_next;
    logic [IW-1:0]   chk_idx_reg, chk_idx_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]   occ_reg, occ_next;
    logic [CW-1:0]   removed_reg, removed_next;
    logic            free_found_reg, free_found_next;
    logic [IW-1:0]   free_idx_reg, free_idx_next;
    status_t         res_status_reg, res_status_next;
    logic [IW-1:0]   res_idx_reg, res_idx_next;
    logic [31:0]     beacon_reg, beacon_next;
    logic            rv_reg, rv_next;
    logic [2:0]      o_status_reg, o_status_next;
    logic [3:0]      o_idx_reg, o_idx_next;
    logic [4:0]      o_removed_reg, o_removed_next;
    logic [4:0]      o_occ_reg, o_occ_next;
    logic            o_due_reg, o_due_next;

    logic            last_slot;
    logic            hit;
    logic            expired;
    logic [31:0]     idle_ms;
    logic [31:0]     since_beacon;

    assign item.ready = (state_reg == S_IDLE);

    assign result.valid         = rv_reg;
    assign result.status        = o_status_reg;
    assign result.slot_index    = o_idx_reg;
    assign result.removed_count = o_removed_reg;
    assign result.occupancy     = o_occ_reg;
    assign result.broadcast_due = o_due_reg;

    // per-slot checks on the entry read last cycle
    assign last_slot    = (chk_idx_reg == IW'(DEPTH - 1));
    assign idle_ms      = item_reg.now_ms - rd_data.last_seen;
    assign expired      = valid_reg[chk_idx_reg] && (idle_ms > peer_ttl_ms);
    assign hit          = valid_reg[chk_idx_reg] && (rd_data.mac == item_reg.src_mac);
    assign since_beacon = item_reg.now_ms - beacon_reg;

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        addr_next       = addr_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        removed_next    = removed_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        beacon_next     = beacon_reg;
        rv_next         = rv_reg;
        o_status_next   = o_status_reg;
        o_idx_next      = o_idx_reg;
        o_removed_next  = o_removed_reg;
        o_occ_next      = o_occ_reg;
        o_due_next      = o_due_reg;

        rd_en   = 1'b0;
        rd_addr = addr_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = chk_idx_reg;
        wr_data = rd_data;

        // result taken by the sink
        if (rv_reg && result.ready)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    item_next.opcode    = item.opcode;
                    item_next.now_ms    = item.now_ms;
                    item_next.src_mac   = item.src_mac;
                    item_next.pkt_len   = item.pkt_len;
                    item_next.pkt_type  = item.pkt_type;
                    item_next.side      = item.side;
                    item_next.is_hunter = item.is_hunter;
                    addr_next       = '0;
                    chk_vld_next    = 1'b0;
                    removed_next    = '0;
                    free_found_next = 1'b0;
                    res_idx_next    = '0;
                    res_status_next = ST_AGED;
                    if ((item.opcode == OP_RX) && (item.pkt_len < HDR_BYTES))
                    begin
                        res_status_next = ST_SHORT;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next slot read
                if (addr_reg < CW'(DEPTH))
                begin
                    rd_en        = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = addr_reg[IW-1:0];
                    addr_next    = addr_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                // evaluate the slot whose data has arrived
                if (chk_vld_reg)
                begin
                    if (item_reg.opcode == OP_AGING)
                    begin
                        if (expired)
                        begin
                            valid_next[chk_idx_reg] = 1'b0;
                            removed_next = removed_reg + 1'b1;
                            occ_next     = occ_reg - 1'b1;
                        end
                        if (last_slot)
                        begin
                            res_status_next = ST_AGED;
                            state_next      = S_FINISH;
                        end
                    end
                    else if (hit)
                    begin
                        // known peer: refresh last-seen, keep the rest
                        wr_en             = 1'b1;
                        wr_addr           = chk_idx_reg;
                        wr_data           = rd_data;
                        wr_data.last_seen = item_reg.now_ms;
                        res_status_next   = ST_REFRESHED;
                        res_idx_next      = chk_idx_reg;
                        state_next        = S_FINISH;
                    end
                    else
                    begin
                        // remember the lowest free slot
                        if (!valid_reg[chk_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        if (last_slot)
                        begin
                            state_next = S_FINISH;
                            if (item_reg.pkt_type != TYPE_PLAYER_INFO)
                            begin
                                res_status_next = ST_IGNORED;
                            end
                            else if (free_found_next)
                            begin
                                wr_en             = 1'b1;
                                wr_addr           = free_idx_next;
                                wr_data.mac       = item_reg.src_mac;
                                wr_data.last_seen = item_reg.now_ms;
                                wr_data.side      = item_reg.side;
                                wr_data.hunter    = item_reg.is_hunter;
                                valid_next[free_idx_next] = 1'b1;
                                occ_next          = occ_reg + 1'b1;
                                res_status_next   = ST_ADDED;
                                res_idx_next      = free_idx_next;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                    end
                end
            end

            S_FINISH:
            begin
                // load the result register once it is free
                if (!rv_reg || result.ready)
                begin
                    rv_next        = 1'b1;
                    o_status_next  = res_status_reg;
                    o_idx_next     = 4'(res_idx_reg);
                    o_removed_next = 5'(removed_reg);
                    o_occ_next     = 5'(occ_reg);
                    o_due_next     = 1'b0;
                    if ((item_reg.opcode == OP_AGING) && (since_beacon >= beacon_interval_ms))
                    begin
                        o_due_next  = 1'b1;
                        beacon_next = item_reg.now_ms;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            addr_reg       <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            valid_reg      <= '0;
            occ_reg        <= '0;
            removed_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            res_status_reg <= ST_SHORT;
            res_idx_reg    <= '0;
            beacon_reg     <= '0;
            rv_reg         <= 1'b0;
            o_status_reg   <= '0;
            o_idx_reg      <= '0;
            o_removed_reg  <= '0;
            o_occ_reg      <= '0;
            o_due_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            item_reg       <= item_next;
            addr_reg       <= addr_next;
            chk_vld_reg    <= chk_vld_next;
            chk_idx_reg    <= chk_idx_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            removed_reg    <= removed_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
            beacon_reg     <= beacon_next;
            rv_reg         <= rv_next;
            o_status_reg   <= o_status_next;
            o_idx_reg      <= o_idx_next;
            o_removed_reg  <= o_removed_next;
            o_occ_reg      <= o_occ_next;
            o_due_reg      <= o_due_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/peer_table_with_aging.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// peer_table_with_aging
// Bounded peer table keyed by source MAC, with refresh, insertion, idle
// expiry and a broadcast interval timer.
//
//   channel   dir  transfer
//   item      in   valid/ready, one packet or aging tick per transfer
//   result    out  valid/ready, one status record per item
//   cfg       in   write enable, index, 32-bit data; no handshake
//
// A short packet goes straight to the final step; any other item scans
// the slots one per cycle through the single read port of the slot
// memory (a refresh stops at the matching slot).
// Reset clears the valid bits at once, so no clearing pass is needed.
// A new item is taken while the previous result still waits; the scan
// holds in its final step until the result register is free.
// ----------------------------------------------------------------------------
module peer_table_with_aging
    import pt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    pt_in_if.sink                      item,
    pt_out_if.source                   result
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [31:0] ttl_reg;
    logic [31:0] interval_reg;

    logic        rd_en;
    logic [IW-1:0] rd_addr;
    peer_entry_t rd_data;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    peer_entry_t wr_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg      <= TTL_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PEER_TTL:     ttl_reg      <= cfg_wdata;
                REG_BEACON_INTVL: interval_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // slot storage
    pt_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // scan sequencer
    pt_engine #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_engine (
        .clk                (clk),
        .rst_n              (rst_n),
        .peer_ttl_ms        (ttl_reg),
        .beacon_interval_ms (interval_reg),
        .item               (item),
        .result             (result),
        .rd_en              (rd_en),
        .rd_addr            (rd_addr),
        .rd_data            (rd_data),
        .wr_en              (wr_en),
        .wr_addr            (wr_addr),
        .wr_data            (wr_data)
    );

endmodule
`default_nettype wire
